// ===== sv/spds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spds_pkg;

   localparam int TABLE_LEN  = 24;
   localparam int TBL_IDX_W  = $clog2(TABLE_LEN);
   localparam int REQ_W      = 10;
   localparam int BASE_W     = 6;
   localparam int X10_W      = 14;
   localparam int DIV_W      = 9;
   localparam int PROD_W     = 15;
   localparam int SECOND_W   = 4;
   localparam int BS_W       = 10;
   localparam int PERIOD_W   = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [BASE_W-1:0]   BASE_RESET  = BASE_W'(25);
   localparam logic [PERIOD_W-1:0] PERIOD_MAX  = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_DIV3     = 1'b1;

   typedef enum logic [1:0] {
      FS_DIV1   = 2'd0,
      FS_DIV1P5 = 2'd1,
      FS_DIV2   = 2'd2,
      FS_DIV3   = 2'd3
   } first_stage_type;

   // Overall divisor times ten, in ascending order.
   localparam logic [DIV_W-1:0] DIV_X10 [TABLE_LEN] = '{
      9'd40,  9'd50,  9'd60,  9'd70,  9'd75,  9'd80,  9'd90,  9'd100,
      9'd105, 9'd110, 9'd120, 9'd135, 9'd140, 9'd150, 9'd160, 9'd165,
      9'd180, 9'd200, 9'd210, 9'd220, 9'd240, 9'd270, 9'd300, 9'd330
   };

   localparam logic [SECOND_W-1:0] SECOND_DIV [TABLE_LEN] = '{
      4'd4,  4'd5,  4'd4,  4'd7,  4'd5,  4'd4,  4'd6,  4'd5,
      4'd7,  4'd11, 4'd8,  4'd9,  4'd7,  4'd10, 4'd8,  4'd11,
      4'd9,  4'd10, 4'd7,  4'd11, 4'd8,  4'd9,  4'd10, 4'd11
   };

   localparam first_stage_type FIRST_CODE [TABLE_LEN] = '{
      FS_DIV1,   FS_DIV1,   FS_DIV1P5, FS_DIV1,   FS_DIV1P5, FS_DIV2,
      FS_DIV1P5, FS_DIV2,   FS_DIV1P5, FS_DIV1,   FS_DIV1P5, FS_DIV1P5,
      FS_DIV2,   FS_DIV1P5, FS_DIV2,   FS_DIV1P5, FS_DIV2,   FS_DIV2,
      FS_DIV3,   FS_DIV2,   FS_DIV3,   FS_DIV3,   FS_DIV3,   FS_DIV3
   };

   typedef struct packed {
      logic                found;
      logic [SECOND_W-1:0] second;
      first_stage_type     code;
   } choice_type;

   typedef struct packed {
      logic                found;
      logic [SECOND_W-1:0] second;
      first_stage_type     code;
      logic [PERIOD_W-1:0] period;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/spds_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spds_match (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   en,
   input  wire                                   in_valid,
   input  wire  [spds_pkg::REQ_W-1:0]            req,
   input  wire  [spds_pkg::BASE_W-1:0]           base,
   input  wire                                   no_div3,
   output logic                                  hit_valid,
   output logic [spds_pkg::TABLE_LEN-1:0]        hit,
   output logic [spds_pkg::BASE_W-1:0]           hit_base
);

   logic                              valid1_ff;
   logic [spds_pkg::X10_W-1:0]        req10_ff, req10_in;
   logic [spds_pkg::PROD_W-1:0]       limit_ff [spds_pkg::TABLE_LEN];
   logic [spds_pkg::PROD_W-1:0]       limit_in [spds_pkg::TABLE_LEN];
   logic [spds_pkg::BASE_W-1:0]       base1_ff;
   logic                              no_div3_1_ff;

   logic                              valid2_ff;
   logic [spds_pkg::TABLE_LEN-1:0]    hit_ff, hit_in;
   logic [spds_pkg::BASE_W-1:0]       base2_ff;

   // floor(10*req / base) <= d  holds exactly when 10*req < (d + 1) * base,
   // so each entry needs only a constant multiple of the base period.
   always_comb begin
      req10_in = (spds_pkg::X10_W'(req) << 3) + (spds_pkg::X10_W'(req) << 1);
      for (int i = 0; i < spds_pkg::TABLE_LEN; i++) begin
         limit_in[i] = spds_pkg::PROD_W'(base)
                     * spds_pkg::PROD_W'(spds_pkg::DIV_X10[i] + spds_pkg::DIV_W'(1));
      end
   end

   always_comb begin
      for (int i = 0; i < spds_pkg::TABLE_LEN; i++) begin
         hit_in[i] = (spds_pkg::PROD_W'(req10_ff) < limit_ff[i])
                   && !(no_div3_1_ff && spds_pkg::FIRST_CODE[i] == spds_pkg::FS_DIV3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req10_ff     <= req10_in;
         limit_ff     <= limit_in;
         base1_ff     <= base;
         no_div3_1_ff <= no_div3;
         hit_ff       <= hit_in;
         base2_ff     <= base1_ff;
      end
   end

   assign hit_valid = valid2_ff;
   assign hit       = hit_ff;
   assign hit_base  = base2_ff;

endmodule

`default_nettype wire

// ===== sv/spds_pick.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spds_pick (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 en,
   input  wire                                 in_valid,
   input  wire  [spds_pkg::TABLE_LEN-1:0]      hit,
   input  wire  [spds_pkg::BASE_W-1:0]         base,
   output logic                                out_valid,
   output spds_pkg::choice_type                choice,
   output logic [spds_pkg::BASE_W-1:0]         out_base
);

   logic                              valid3_ff;
   spds_pkg::choice_type              choice_ff, choice_in;
   logic [spds_pkg::BASE_W-1:0]       base3_ff;
   logic [spds_pkg::TBL_IDX_W-1:0]    sel_idx;

   // The lowest set hit is the first entry that meets the period.
   always_comb begin
      sel_idx = '0;
      for (int i = spds_pkg::TABLE_LEN - 1; i >= 0; i--) begin
         if (hit[i]) begin
            sel_idx = spds_pkg::TBL_IDX_W'(i);
         end
      end
      if (|hit) begin
         choice_in.found  = 1'b1;
         choice_in.second = spds_pkg::SECOND_DIV[sel_idx];
         choice_in.code   = spds_pkg::FIRST_CODE[sel_idx];
      end else begin
         choice_in.found  = 1'b0;
         choice_in.second = '0;
         choice_in.code   = spds_pkg::FS_DIV1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else if (en) begin
         valid3_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         choice_ff <= choice_in;
         base3_ff  <= base;
      end
   end

   assign out_valid = valid3_ff;
   assign choice    = choice_ff;
   assign out_base  = base3_ff;

endmodule

`default_nettype wire

// ===== sv/spds_period.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spds_period (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           en,
   input  wire                           in_valid,
   input  wire  spds_pkg::choice_type    choice,
   input  wire  [spds_pkg::BASE_W-1:0]   base,
   output logic                          out_valid,
   output spds_pkg::result_type          result
);

   localparam int WIDE_W = spds_pkg::BS_W + 2;

   logic                            valid4_ff;
   spds_pkg::choice_type            choice4_ff;
   logic [spds_pkg::BS_W-1:0]       bs_ff, bs_in;
   logic [WIDE_W-1:0]               bs_wide;
   logic [WIDE_W-1:0]               period_wide;

   // A choice that was not found carries a zero divisor, so its period is zero.
   assign bs_in = spds_pkg::BS_W'(base) * spds_pkg::BS_W'(choice.second);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else if (en) begin
         valid4_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         choice4_ff <= choice;
         bs_ff      <= bs_in;
      end
   end

   // Rounding 1.5 * p half up reduces to (3 * p + 1) / 2.
   always_comb begin
      bs_wide = WIDE_W'(bs_ff);
      case (choice4_ff.code)
         spds_pkg::FS_DIV1:   period_wide = bs_wide;
         spds_pkg::FS_DIV1P5: period_wide = ((bs_wide << 1) + bs_wide + WIDE_W'(1)) >> 1;
         spds_pkg::FS_DIV2:   period_wide = bs_wide << 1;
         spds_pkg::FS_DIV3:   period_wide = (bs_wide << 1) + bs_wide;
         default:             period_wide = '0;
      endcase
      result.found  = choice4_ff.found;
      result.second = choice4_ff.second;
      result.code   = choice4_ff.code;
      if (period_wide > WIDE_W'(spds_pkg::PERIOD_MAX)) begin
         result.period = spds_pkg::PERIOD_MAX;
      end else begin
         result.period = period_wide[spds_pkg::PERIOD_W-1:0];
      end
   end

   assign out_valid = valid4_ff;

endmodule

`default_nettype wire

// ===== sv/spds_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spds_out (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   input  wire  spds_pkg::result_type in_result,
   input  wire                     out_ready,
   output logic                    out_valid,
   output spds_pkg::result_type    out_result,
   output logic                    en
);

   logic                   out_valid_ff, out_valid_in;
   spds_pkg::result_type   out_ff, out_in;
   logic                   skid_valid_ff, skid_valid_in;
   spds_pkg::result_type   skid_ff, skid_in;
   logic                   take;

   // The pipeline only moves while the skid word is empty, so a word that
   // arrives as the output stalls always has somewhere to go.
   assign en   = !skid_valid_ff;
   assign take = in_valid && en;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || out_ready) begin
         skid_valid_in = 1'b0;
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = skid_ff;
         end else begin
            out_valid_in = take;
            out_in       = in_result;
         end
      end else if (take) begin
         skid_valid_in = 1'b1;
         skid_in       = in_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

endmodule

`default_nettype wire

// ===== sv/sync_period_divisor_select.sv =====
// A word accepted on req_ loads the first of four pipeline stages, and the
// output register that drives rsp_ follows the last one.
// Throughput: one word per cycle while rsp_tready is high; the compare
// against all 24 table entries runs in parallel, so nothing iterates.
// Reset (synchronous, active high) empties the pipeline and sets the base
// period to 25 ns with divide-by-three entries allowed.
`timescale 1ns / 1ps
`default_nettype none

module sync_period_divisor_select (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [15:0]                        req_tdata,   // [9:0] requested_period_ns
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [3:0] second_stage_divisor, [5:4] first_stage_code, [16:6] achieved_period_ns
   output logic [23:0]                        rsp_tdata,
   output logic                               rsp_tuser,   // [0] found
   input  wire                                csr_wr_en,
   input  wire  [spds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [spds_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [spds_pkg::BASE_W-1:0]      base_ff;
   logic                             no_div3_ff;
   logic                             en;

   logic                             hit_valid;
   logic [spds_pkg::TABLE_LEN-1:0]   hit;
   logic [spds_pkg::BASE_W-1:0]      hit_base;

   logic                             pick_valid;
   spds_pkg::choice_type             choice;
   logic [spds_pkg::BASE_W-1:0]      pick_base;

   logic                             res_valid;
   spds_pkg::result_type             result;
   spds_pkg::result_type             rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= spds_pkg::BASE_RESET;
         no_div3_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            spds_pkg::CSR_BASE_PERIOD: base_ff    <= csr_wdata[spds_pkg::BASE_W-1:0];
            spds_pkg::CSR_NO_DIV3:     no_div3_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_tready = en;

   spds_match u_match (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .req       (req_tdata[spds_pkg::REQ_W-1:0]),
      .base      (base_ff),
      .no_div3   (no_div3_ff),
      .hit_valid (hit_valid),
      .hit       (hit),
      .hit_base  (hit_base)
   );

   spds_pick u_pick (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (hit_valid),
      .hit       (hit),
      .base      (hit_base),
      .out_valid (pick_valid),
      .choice    (choice),
      .out_base  (pick_base)
   );

   spds_period u_period (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pick_valid),
      .choice    (choice),
      .base      (pick_base),
      .out_valid (res_valid),
      .result    (result)
   );

   spds_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (res_valid),
      .in_result  (result),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (rsp_result),
      .en         (en)
   );

   assign rsp_tdata = {7'b0, rsp_result.period, rsp_result.code, rsp_result.second};
   assign rsp_tuser = rsp_result.found;

endmodule

`default_nettype wire

// ===== sv/spds_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spds_checker (
   input wire         clock,
   input wire         reset,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [23:0]  rsp_tdata,
   input wire         rsp_tuser
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // A miss carries all-zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("miss with non-zero fields");

   // A hit always names a second stage divisor between 4 and 11.
   a_hit_second: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[3:0] >= 4'd4 && rsp_tdata[3:0] <= 4'd11)
      else $error("second stage divisor out of range");

   // A hit implies a non-zero base period, hence a non-zero achieved period.
   a_hit_period: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[16:6] != 11'd0)
      else $error("hit with zero achieved period");

endmodule

bind sync_period_divisor_select spds_checker u_spds_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
